// File: rtl/core/scc_pkg.sv
// Shared types and constants for the shunt coulomb counter.
package scc_pkg;

    // Widths of the item fields and configuration port
    localparam int unsigned SHUNT_W  = 16;
    localparam int unsigned BUS_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CHARGE_W = 64;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_READ_ERR   = 3'd1,
        ST_SATURATED  = 3'd2,
        ST_RANGE      = 3'd3,
        ST_RESET_DONE = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_MS    = 3'd4;

    // Configuration reset values
    localparam logic [15:0]       RST_SAT_THRESHOLD = 16'd32441;
    localparam logic [BUS_W-1:0]  RST_BUS_MIN       = 16'd0;
    localparam logic [BUS_W-1:0]  RST_BUS_MAX       = 16'hFFFF;
    localparam logic [15:0]       RST_CURRENT_LIMIT = 16'd32768;
    localparam logic [TIME_W-1:0] RST_MAX_GAP_MS    = 32'd60000;

    // Live configuration
    typedef struct packed {
        logic [15:0]       sat_threshold;
        logic [BUS_W-1:0]  bus_min;
        logic [BUS_W-1:0]  bus_max;
        logic [15:0]       current_limit;
        logic [TIME_W-1:0] max_gap_ms;
    } t_cfg;

    // One input transaction
    typedef struct packed {
        logic              operation;
        logic [SHUNT_W-1:0] shunt_raw;
        logic [BUS_W-1:0]  bus_raw;
        logic [TIME_W-1:0] time_ms;
        logic              read_failed;
    } t_sample;

    // One result transaction
    typedef struct packed {
        logic                valid_res;
        t_status             status;
        logic [CHARGE_W-1:0] charge;
        logic [COUNT_W-1:0]  error_count;
        logic [COUNT_W-1:0]  sat_count;
    } t_result;

endpackage

// File: rtl/core/scc_cfg_regs.sv
// Configuration register file of the shunt coulomb counter.
module scc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [scc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output scc_pkg::t_cfg                    o_cfg
);

    scc_pkg::t_cfg r_cfg;

    // Load defaults on reset, then take indexed writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sat_threshold <= scc_pkg::RST_SAT_THRESHOLD;
            r_cfg.bus_min       <= scc_pkg::RST_BUS_MIN;
            r_cfg.bus_max       <= scc_pkg::RST_BUS_MAX;
            r_cfg.current_limit <= scc_pkg::RST_CURRENT_LIMIT;
            r_cfg.max_gap_ms    <= scc_pkg::RST_MAX_GAP_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scc_pkg::CFG_SAT_THRESHOLD: r_cfg.sat_threshold <= i_cfg_data[15:0];
                scc_pkg::CFG_BUS_MIN:       r_cfg.bus_min       <= i_cfg_data[15:0];
                scc_pkg::CFG_BUS_MAX:       r_cfg.bus_max       <= i_cfg_data[15:0];
                scc_pkg::CFG_CURRENT_LIMIT: r_cfg.current_limit <= i_cfg_data[15:0];
                scc_pkg::CFG_MAX_GAP_MS:    r_cfg.max_gap_ms    <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/scc_datapath.sv
// Charge integration, counters and sample classification.
module scc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  scc_pkg::t_sample  i_sample,
    input  scc_pkg::t_cfg     i_cfg,
    output scc_pkg::t_result  o_result
);

    localparam int unsigned PROD_W = scc_pkg::SHUNT_W + scc_pkg::TIME_W + 1;
    localparam int unsigned SUM_W  = scc_pkg::CHARGE_W + 1;

    // Accumulator state
    logic [scc_pkg::CHARGE_W-1:0] r_charge_acc, n_charge_acc;
    logic [scc_pkg::TIME_W-1:0]   r_last_time,  n_last_time;
    logic                         r_started,    n_started;
    logic [scc_pkg::COUNT_W-1:0]  r_err_total,  n_err_total;
    logic [scc_pkg::COUNT_W-1:0]  r_sat_total,  n_sat_total;

    logic signed [scc_pkg::SHUNT_W-1:0] shunt;
    logic [scc_pkg::SHUNT_W:0]          mag;
    logic [scc_pkg::TIME_W-1:0]         dt;
    logic signed [PROD_W-1:0]           prod;
    logic [SUM_W-1:0]                   sum;
    logic [scc_pkg::CHARGE_W-1:0]       acc_sat;
    logic                               integrate;
    logic                               saturated;
    logic                               out_of_range;
    logic [scc_pkg::COUNT_W-1:0]        err_inc;
    logic [scc_pkg::COUNT_W-1:0]        sat_inc;

    // Magnitude of the shunt reading, one bit wider to hold 32768
    assign shunt = $signed(i_sample.shunt_raw);
    assign mag   = shunt[scc_pkg::SHUNT_W-1] ?
                   (~{1'b1, i_sample.shunt_raw} + 1'b1) : {1'b0, i_sample.shunt_raw};

    // Elapsed time and charge increment
    assign dt   = i_sample.time_ms - r_last_time;
    assign prod = shunt * $signed({1'b0, dt});

    // Saturating 64-bit add
    assign sum = {r_charge_acc[scc_pkg::CHARGE_W-1], r_charge_acc}
               + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    always_comb begin
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            acc_sat = sum[SUM_W-1] ? {1'b1, {(scc_pkg::CHARGE_W-1){1'b0}}}
                                   : {1'b0, {(scc_pkg::CHARGE_W-1){1'b1}}};
        end else begin
            acc_sat = sum[scc_pkg::CHARGE_W-1:0];
        end
    end

    assign integrate    = r_started && (dt < i_cfg.max_gap_ms);
    assign saturated    = mag >= {1'b0, i_cfg.sat_threshold};
    assign out_of_range = (i_sample.bus_raw < i_cfg.bus_min)
                       || (i_sample.bus_raw > i_cfg.bus_max)
                       || (mag > {1'b0, i_cfg.current_limit});

    // Saturating counter increments
    assign err_inc = (&r_err_total) ? r_err_total : r_err_total + 1'b1;
    assign sat_inc = (&r_sat_total) ? r_sat_total : r_sat_total + 1'b1;

    // Classify the transaction and compute next state and result
    always_comb begin
        n_charge_acc = r_charge_acc;
        n_last_time  = r_last_time;
        n_started    = r_started;
        n_err_total  = r_err_total;
        n_sat_total  = r_sat_total;
        o_result.valid_res = 1'b0;
        o_result.status    = scc_pkg::ST_OK;
        o_result.charge    = '0;
        if (i_sample.operation == scc_pkg::OP_CLEAR) begin
            n_charge_acc    = '0;
            n_started       = 1'b0;
            o_result.status = scc_pkg::ST_RESET_DONE;
        end else if (i_sample.read_failed) begin
            n_err_total     = err_inc;
            o_result.status = scc_pkg::ST_READ_ERR;
        end else if (saturated) begin
            n_sat_total     = sat_inc;
            o_result.status = scc_pkg::ST_SATURATED;
        end else begin
            if (integrate) begin
                n_charge_acc = acc_sat;
            end
            n_last_time     = i_sample.time_ms;
            n_started       = 1'b1;
            o_result.charge = n_charge_acc;
            if (out_of_range) begin
                n_err_total     = err_inc;
                o_result.status = scc_pkg::ST_RANGE;
            end else begin
                o_result.valid_res = 1'b1;
            end
        end
        o_result.error_count = n_err_total;
        o_result.sat_count   = n_sat_total;
    end

    // Advance state on each processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_acc <= '0;
            r_last_time  <= '0;
            r_started    <= 1'b0;
            r_err_total  <= '0;
            r_sat_total  <= '0;
        end else if (i_fire) begin
            r_charge_acc <= n_charge_acc;
            r_last_time  <= n_last_time;
            r_started    <= n_started;
            r_err_total  <= n_err_total;
            r_sat_total  <= n_sat_total;
        end
    end

endmodule

// File: rtl/core/shunt_coulomb_counter_top.sv
// Top level of the shunt coulomb counter: input register, datapath, result register.
// Path: an accepted input transaction is held in the input register, then its result is
// registered into the result register, from which it can be taken.
// Throughput: one transaction per cycle while the output is not stalled; the 16x33 multiply
// and 64-bit saturating add between the input register and the result register set the cycle.
// Reset (synchronous, active low) clears charge, timestamps, counters and the valid
// flags of both pipeline registers, and loads the configuration defaults.
module shunt_coulomb_counter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [scc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_operation,
    input  logic signed [scc_pkg::SHUNT_W-1:0]    i_shunt_raw,
    input  logic [scc_pkg::BUS_W-1:0]             i_bus_raw,
    input  logic [scc_pkg::TIME_W-1:0]            i_time_ms,
    input  logic                                  i_read_failed,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_valid_res,
    output logic [scc_pkg::STATUS_W-1:0]          o_status,
    output logic signed [scc_pkg::CHARGE_W-1:0]   o_charge,
    output logic [scc_pkg::COUNT_W-1:0]           o_error_count,
    output logic [scc_pkg::COUNT_W-1:0]           o_sat_count
);

    scc_pkg::t_cfg    cfg;
    scc_pkg::t_sample r_in;
    logic             r_in_valid;
    scc_pkg::t_result r_out;
    logic             r_out_valid;
    scc_pkg::t_result result;
    logic             fire;
    logic             in_take;
    logic             out_take;

    scc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: process when the result register is free or draining
    assign out_take   = r_out_valid && !i_out_stall;
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.operation   <= i_operation;
            r_in.shunt_raw   <= i_shunt_raw;
            r_in.bus_raw     <= i_bus_raw;
            r_in.time_ms     <= i_time_ms;
            r_in.read_failed <= i_read_failed;
        end
    end

    scc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_valid_res   = r_out.valid_res;
    assign o_status      = r_out.status;
    assign o_charge      = $signed(r_out.charge);
    assign o_error_count = r_out.error_count;
    assign o_sat_count   = r_out.sat_count;

endmodule

// File: rtl/core/scc_checker.sv
// Port-level checker for the shunt coulomb counter, bound to the top level.
module scc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_valid_res,
    input logic [scc_pkg::STATUS_W-1:0]        o_status,
    input logic signed [scc_pkg::CHARGE_W-1:0] o_charge,
    input logic [scc_pkg::COUNT_W-1:0]         o_error_count,
    input logic [scc_pkg::COUNT_W-1:0]         o_sat_count
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_charge)
            && $stable(o_status) && $stable(o_error_count) && $stable(o_sat_count))
        else $error("stalled result changed");

    // Good samples carry ok status, and ok status means good
    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_valid_res == (o_status == scc_pkg::ST_OK)))
        else $error("valid flag and status disagree");

    // Clear, read-error and saturated results report zero charge
    a_zero_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == scc_pkg::ST_RESET_DONE
            || o_status == scc_pkg::ST_READ_ERR
            || o_status == scc_pkg::ST_SATURATED) |-> o_charge == '0)
        else $error("nonzero charge on a non-integrating result");

    // Empty result register never back-pressures the input
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind shunt_coulomb_counter_top scc_checker u_scc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_valid_res   (o_valid_res),
    .o_status      (o_status),
    .o_charge      (o_charge),
    .o_error_count (o_error_count),
    .o_sat_count   (o_sat_count)
);

// File: tb/sv/scc_charge_checker.sv
// Result checker for the shunt coulomb counter: predicts every result and compares it.
module scc_charge_checker
    import scc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Register write port, watched only
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Sample channel
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_operation,
    input  logic [SHUNT_W-1:0]    i_shunt_raw,
    input  logic [BUS_W-1:0]      i_bus_raw,
    input  logic [TIME_W-1:0]     i_time_ms,
    input  logic                  i_read_failed,
    // Result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_valid_res,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [CHARGE_W-1:0]   i_charge,
    input  logic [COUNT_W-1:0]    i_error_count,
    input  logic [COUNT_W-1:0]    i_sat_count,
    // Results still owed by the block, and mismatches seen so far
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the block's registers and accumulator state
    t_cfg                       cfg_shadow;
    logic signed [CHARGE_W-1:0] charge_sum;
    logic [TIME_W-1:0]          last_stamp;
    logic                       integrating;
    logic [COUNT_W-1:0]         error_total;
    logic [COUNT_W-1:0]         sat_total;
    t_result                    owed_results[$];

    // Count up, hold at all ones
    function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Signed add that clamps at the 64-bit limits
    function automatic logic signed [CHARGE_W-1:0] add_clamped(
        input logic signed [CHARGE_W-1:0] acc,
        input logic signed [CHARGE_W-1:0] delta
    );
        logic signed [CHARGE_W:0] wide;
        wide = {acc[CHARGE_W-1], acc} + {delta[CHARGE_W-1], delta};
        if (wide[CHARGE_W] != wide[CHARGE_W-1]) begin
            return wide[CHARGE_W] ? {1'b1, {(CHARGE_W-1){1'b0}}}
                                  : {1'b0, {(CHARGE_W-1){1'b1}}};
        end
        return wide[CHARGE_W-1:0];
    endfunction

    // Advance the shadow state by one sample and build the result it should give
    task automatic integrate_sample(input t_sample s, output t_result r);
        logic signed [SHUNT_W-1:0] shunt;
        logic [16:0]               magnitude;
        logic [TIME_W-1:0]         elapsed;
        longint                    product;
        shunt     = s.shunt_raw;
        magnitude = shunt[SHUNT_W-1] ? (17'h1_0000 - 17'(s.shunt_raw)) : 17'(s.shunt_raw);
        r         = '0;
        r.status  = ST_OK;
        if (s.operation == OP_CLEAR) begin
            charge_sum  = '0;
            integrating = 1'b0;
            r.status    = ST_RESET_DONE;
        end else if (s.read_failed) begin
            error_total = bump_count(error_total);
            r.status    = ST_READ_ERR;
        end else if (magnitude >= 17'(cfg_shadow.sat_threshold)) begin
            // Saturated reading: timestamp and started flag stay as they are
            sat_total = bump_count(sat_total);
            r.status  = ST_SATURATED;
        end else begin
            if (integrating) begin
                elapsed = s.time_ms - last_stamp;
                if (elapsed < cfg_shadow.max_gap_ms) begin
                    product    = longint'(shunt) * longint'({32'b0, elapsed});
                    charge_sum = add_clamped(charge_sum, product);
                end
            end
            last_stamp  = s.time_ms;
            integrating = 1'b1;
            r.charge    = charge_sum;
            if (s.bus_raw < cfg_shadow.bus_min || s.bus_raw > cfg_shadow.bus_max ||
                magnitude > 17'(cfg_shadow.current_limit)) begin
                error_total = bump_count(error_total);
                r.status    = ST_RANGE;
            end else begin
                r.valid_res = 1'b1;
            end
        end
        r.error_count = error_total;
        r.sat_count   = sat_total;
    endtask

    // Track registers, check results, then queue the prediction for a new sample
    always @(posedge i_clk) begin
        t_result want;
        t_sample got;
        if (!i_rst_n) begin
            cfg_shadow.sat_threshold = RST_SAT_THRESHOLD;
            cfg_shadow.bus_min       = RST_BUS_MIN;
            cfg_shadow.bus_max       = RST_BUS_MAX;
            cfg_shadow.current_limit = RST_CURRENT_LIMIT;
            cfg_shadow.max_gap_ms    = RST_MAX_GAP_MS;
            charge_sum   = '0;
            last_stamp   = '0;
            integrating  = 1'b0;
            error_total  = '0;
            sat_total    = '0;
            owed_results.delete();
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAT_THRESHOLD: cfg_shadow.sat_threshold = i_cfg_data[15:0];
                    CFG_BUS_MIN:       cfg_shadow.bus_min       = i_cfg_data[BUS_W-1:0];
                    CFG_BUS_MAX:       cfg_shadow.bus_max       = i_cfg_data[BUS_W-1:0];
                    CFG_CURRENT_LIMIT: cfg_shadow.current_limit = i_cfg_data[15:0];
                    CFG_MAX_GAP_MS:    cfg_shadow.max_gap_ms    = i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end

            // Results leave only after their sample has passed the input and result registers, so check first
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result with nothing expected: status %0d, charge %0d",
                           i_status, $signed(i_charge));
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_valid_res !== want.valid_res) begin
                        $error("valid_res mismatch: expected %0d, actual %0d",
                               want.valid_res, i_valid_res);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_charge !== want.charge) begin
                        $error("charge mismatch: expected %0d, actual %0d",
                               $signed(want.charge), $signed(i_charge));
                        o_fail_count++;
                    end
                    if (i_error_count !== want.error_count) begin
                        $error("error_count mismatch: expected %0d, actual %0d",
                               want.error_count, i_error_count);
                        o_fail_count++;
                    end
                    if (i_sat_count !== want.sat_count) begin
                        $error("sat_count mismatch: expected %0d, actual %0d",
                               want.sat_count, i_sat_count);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                got.operation   = i_operation;
                got.shunt_raw   = i_shunt_raw;
                got.bus_raw     = i_bus_raw;
                got.time_ms     = i_time_ms;
                got.read_failed = i_read_failed;
                integrate_sample(got, want);
                owed_results.push_back(want);
            end
            o_pending = owed_results.size();
        end
    end

endmodule

// File: tb/sv/shunt_coulomb_counter_top_tb.sv
// Testbench top for the shunt coulomb counter: sample and register stimulus, and the verdict.
module shunt_coulomb_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_operation;
    logic [SHUNT_W-1:0]    i_shunt_raw;
    logic [BUS_W-1:0]      i_bus_raw;
    logic [TIME_W-1:0]     i_time_ms;
    logic                  i_read_failed;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_valid_res;
    logic [STATUS_W-1:0]   o_status;
    logic [CHARGE_W-1:0]   o_charge;
    logic [COUNT_W-1:0]    o_error_count;
    logic [COUNT_W-1:0]    o_sat_count;

    int                    pending;
    int                    fail_count;
    int unsigned           cycle_count;
    t_cfg                  active_cfg;
    logic [TIME_W-1:0]     stamp;
    bit                    no_idle;

    shunt_coulomb_counter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_shunt_raw   (i_shunt_raw),
        .i_bus_raw     (i_bus_raw),
        .i_time_ms     (i_time_ms),
        .i_read_failed (i_read_failed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_valid_res   (o_valid_res),
        .o_status      (o_status),
        .o_charge      (o_charge),
        .o_error_count (o_error_count),
        .o_sat_count   (o_sat_count)
    );

    scc_charge_checker charge_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_shunt_raw   (i_shunt_raw),
        .i_bus_raw     (i_bus_raw),
        .i_time_ms     (i_time_ms),
        .i_read_failed (i_read_failed),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_valid_res   (o_valid_res),
        .i_status      (o_status),
        .i_charge      (o_charge),
        .i_error_count (o_error_count),
        .i_sat_count   (o_sat_count),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // End the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[shunt_coulomb_counter_top] ERROR");
        $finish;
    end

    // Result side: stall at random before taking each transaction
    initial begin
        int unsigned hold;
        i_out_stall = 1'b0;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic t_sample sample_of(input logic op, input logic [SHUNT_W-1:0] shunt,
                                          input logic [BUS_W-1:0] bus,
                                          input logic [TIME_W-1:0] ms, input logic failed);
        t_sample s;
        s.operation   = op;
        s.shunt_raw   = shunt;
        s.bus_raw     = bus;
        s.time_ms     = ms;
        s.read_failed = failed;
        return s;
    endfunction

    // Mostly well-formed sample streams with small time steps, plus noise near every limit
    function automatic t_sample random_sample();
        t_sample s;
        s.operation   = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_SAMPLE;
        s.read_failed = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: s.shunt_raw = 16'($urandom_range(0, 4000) - 2000);
            5, 6, 7:       s.shunt_raw = 16'($urandom);
            8: begin
                s.shunt_raw = 16'(active_cfg.sat_threshold + $urandom_range(0, 4) - 2);
                if ($urandom_range(0, 1) == 1) s.shunt_raw = -s.shunt_raw;
            end
            default: begin
                s.shunt_raw = 16'(active_cfg.current_limit + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1) == 1) s.shunt_raw = -s.shunt_raw;
            end
        endcase
        case ($urandom_range(0, 3))
            0, 1:    s.bus_raw = 16'($urandom);
            2:       s.bus_raw = 16'(active_cfg.bus_min + $urandom_range(0, 2) - 1);
            default: s.bus_raw = 16'(active_cfg.bus_max + $urandom_range(0, 2) - 1);
        endcase
        case ($urandom_range(0, 11))
            0:       ;
            1:       stamp = stamp + active_cfg.max_gap_ms + $urandom_range(0, 2) - 1;
            2:       stamp = $urandom;
            3:       stamp = stamp + $urandom;
            default: stamp = stamp + $urandom_range(1, 2000);
        endcase
        s.time_ms = stamp;
        return s;
    endfunction

    task automatic send_sample(input t_sample s);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= s.operation;
        i_shunt_raw   <= s.shunt_raw;
        i_bus_raw     <= s.bus_raw;
        i_time_ms     <= s.time_ms;
        i_read_failed <= s.read_failed;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold off the sample side until every result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Write all five registers back to back; only called with the block idle
    task automatic program_regs(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SAT_THRESHOLD;
        i_cfg_data  <= 32'(c.sat_threshold);
        @(posedge i_clk);
        i_cfg_index <= CFG_BUS_MIN;
        i_cfg_data  <= 32'(c.bus_min);
        @(posedge i_clk);
        i_cfg_index <= CFG_BUS_MAX;
        i_cfg_data  <= 32'(c.bus_max);
        @(posedge i_clk);
        i_cfg_index <= CFG_CURRENT_LIMIT;
        i_cfg_data  <= 32'(c.current_limit);
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_GAP_MS;
        i_cfg_data  <= c.max_gap_ms;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_cfg = c;
    endtask

    task automatic run_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 149) == 0) wait_idle();
            send_sample(random_sample());
        end
    endtask

    initial begin
        t_cfg c;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_operation   = OP_SAMPLE;
        i_shunt_raw   = '0;
        i_bus_raw     = '0;
        i_time_ms     = '0;
        i_read_failed = 1'b0;
        no_idle       = 1'b0;
        stamp         = '0;
        active_cfg    = '{RST_SAT_THRESHOLD, RST_BUS_MIN, RST_BUS_MAX,
                          RST_CURRENT_LIMIT, RST_MAX_GAP_MS};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings
        send_sample(sample_of(OP_CLEAR, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        send_sample(sample_of(OP_SAMPLE, 16'd100, 16'd500, 32'd1000, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'h7FFF, 16'd500, 32'd1100, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'h8000, 16'd500, 32'd1200, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd32441, 16'd500, 32'd1300, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd32440, 16'd0, 32'd1500, 1'b0));
        send_sample(sample_of(OP_SAMPLE, -16'sd32440, 16'hFFFF, 32'd2500, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd50, 16'd500, 32'd2600, 1'b1));
        // gap exactly at the limit is skipped, one below is integrated
        send_sample(sample_of(OP_SAMPLE, 16'd7, 16'd500, 32'd62500, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd9, 16'd500, 32'd122499, 1'b0));
        // timestamp wrap
        send_sample(sample_of(OP_SAMPLE, 16'hFFFF, 16'd500, 32'hFFFF_FF00, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd3, 16'd500, 32'h0000_0100, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd0, 16'd500, 32'h0000_0100, 1'b0));
        send_sample(sample_of(OP_CLEAR, 16'd0, 16'd0, 32'd0, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'h1234, 16'hAAAA, 32'hAAAA_5555, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'hEDCB, 16'h5555, 32'h5555_AAAA, 1'b0));
        stamp = 32'h5555_AAAA;
        run_random(350);

        // Tight ranges: every range failure and full-scale saturation
        wait_idle();
        c = '{16'd32768, 16'd1000, 16'd60000, 16'd20000, 32'd5000};
        program_regs(c);
        send_sample(sample_of(OP_SAMPLE, 16'd10, 16'd999, 32'd100, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd10, 16'd60001, 32'd200, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd20001, 16'd1000, 32'd300, 1'b0));
        send_sample(sample_of(OP_SAMPLE, -16'sd20001, 16'd60000, 32'd400, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'd20000, 16'd1000, 32'd500, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'h8000, 16'd2000, 32'd600, 1'b0));
        send_sample(sample_of(OP_SAMPLE, 16'h8001, 16'd2000, 32'd700, 1'b0));
        stamp = 32'd700;
        run_random(350);

        // Zero threshold: every sample that reads without error saturates
        wait_idle();
        c = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 32'd1};
        program_regs(c);
        run_random(80);

        // Widest settings: no range errors, any gap below all ones integrates
        wait_idle();
        c = '{16'd32768, 16'd0, 16'hFFFF, 16'd32768, 32'hFFFF_FFFF};
        program_regs(c);
        run_random(400);

        // Random settings
        wait_idle();
        c.sat_threshold = 16'($urandom_range(1, 32768));
        c.bus_min       = 16'($urandom_range(0, 30000));
        c.bus_max       = 16'($urandom_range(35000, 65535));
        c.current_limit = 16'($urandom_range(0, 32768));
        c.max_gap_ms    = $urandom_range(1, 200000);
        program_regs(c);
        run_random(370);

        // Narrow window: only bus all ones and zero current pass
        wait_idle();
        c = '{16'd100, 16'hFFFF, 16'hFFFF, 16'd0, 32'd2};
        program_regs(c);
        run_random(300);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[shunt_coulomb_counter_top] OK");
        end else begin
            $display("[shunt_coulomb_counter_top] ERROR");
        end
        $finish;
    end

endmodule
